>>> rtl/core/fdre_pkg.sv
`timescale 1ns / 1ps
package fdre_pkg;

  localparam int DVD_W = 90;
  localparam int DVS_W = 57;
  localparam int ITER_W = 7;

  localparam logic [ITER_W-1:0] DEFL_ITERS = 7'd90;
  localparam logic [ITER_W-1:0] RATE_ITERS = 7'd58;
  localparam logic [ITER_W-1:0] AVG_ITERS  = 7'd41;

  localparam logic [2:0] REG_LEFT_STIFF  = 3'd0;
  localparam logic [2:0] REG_LEFT_DAMP   = 3'd1;
  localparam logic [2:0] REG_RIGHT_STIFF = 3'd2;
  localparam logic [2:0] REG_RIGHT_DAMP  = 3'd3;
  localparam logic [2:0] REG_STEP_TIME   = 3'd4;
  localparam logic [2:0] REG_WINDOW_LEN  = 3'd5;

  typedef struct packed {
    logic        flag;
    logic [31:0] val;
  } sat_t;

  typedef struct packed {
    logic        start;
    logic        side;
    logic [31:0] torque;
    logic [31:0] stiff;
    logic [31:0] damp;
    logic [23:0] dt;
  } lane_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] defl;
    logic [31:0] avg;
    logic        flag;
  } lane_res_t;

  // Clips a sign and magnitude pair to the signed 32-bit range.
  function automatic sat_t sat32(input logic neg, input logic [DVD_W-1:0] mag);
    sat_t s;
    s.flag = 1'b0;
    if (neg) begin
      if (mag > DVD_W'(64'h80000000)) begin
        s.flag = 1'b1;
        s.val  = 32'h80000000;
      end else begin
        s.val = 32'(-mag[31:0]);
      end
    end else begin
      if (mag > DVD_W'(64'h7FFFFFFF)) begin
        s.flag = 1'b1;
        s.val  = 32'h7FFFFFFF;
      end else begin
        s.val = mag[31:0];
      end
    end
    return s;
  endfunction

endpackage

>>> rtl/core/flex_deflection_rate_estimator.sv
`timescale 1ns / 1ps
// Hip flex deflection and rate estimator. A request carries one side's pitch
// and roll torque; a pitch lane and a roll lane each solve the spring-damper
// deflection, the instantaneous rate and the moving average of that side, and
// the results are merged into one output request. A request passes from
// acceptance through the lane multiplier, then the lane's bit-serial divider
// for deflection, rate and average, and then sequencing, merging and handover
// before the next one can be accepted. When a deflection denominator is zero
// that lane skips its first division, but the merge still waits for the other
// lane. The next request is taken as soon as the previous result has moved
// into the output register, even if it is still waiting to be taken there.
module flex_deflection_rate_estimator #(
  parameter int MAX_WINDOW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,   // torque_pitch [31:0], torque_roll [63:32]
  input  logic [0:0]    in_tuser,   // side [0]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // deflection_pitch, deflection_roll, rate_pitch, rate_roll
  output logic [0:0]    out_tuser,  // saturated [0]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W  = (CNT_W > 7) ? CNT_W : 7;

  logic [63:0] left_stiff_r, left_damp_r, right_stiff_r, right_damp_r;
  logic [23:0] step_time_r;
  logic [6:0]  window_len_r;
  logic [SLOT_W-1:0] slot_r [2];
  logic [CNT_W-1:0]  fill_r [2];
  logic        busy_r, out_valid_r;
  logic [127:0] out_data_r;
  logic        out_sat_r;

  logic        cfg_we, accept, clear, side, capture, full_c;
  logic [LEN_W-1:0] len_c, slot_ext, slot_inc;
  logic [SLOT_W-1:0] slot_c, slot_nxt;
  logic [CNT_W-1:0]  fill_c, fill_nxt;
  logic [63:0] stiff_c, damp_c;
  fdre_pkg::lane_req_t req_pitch, req_roll;
  fdre_pkg::lane_res_t res_pitch, res_roll;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign clear     = cfg_we && (cfg_index == fdre_pkg::REG_WINDOW_LEN);
  assign in_tready = !busy_r;
  assign accept    = in_tvalid & in_tready;
  assign side      = in_tuser[0];

  always_comb begin
    if (window_len_r == '0) len_c = LEN_W'(1);
    else if (LEN_W'(window_len_r) > LEN_W'(MAX_WINDOW)) len_c = LEN_W'(MAX_WINDOW);
    else len_c = LEN_W'(window_len_r);
    slot_ext = LEN_W'(slot_r[side]);
    slot_c   = (slot_ext >= len_c) ? '0 : slot_r[side];
    fill_c   = (LEN_W'(fill_r[side]) > len_c) ? CNT_W'(len_c) : fill_r[side];
    full_c   = LEN_W'(fill_c) >= len_c;
    fill_nxt = full_c ? fill_c : CNT_W'(fill_c + 1'b1);
    slot_inc = LEN_W'(slot_c) + LEN_W'(1);
    slot_nxt = (slot_inc >= len_c) ? '0 : SLOT_W'(slot_inc);
  end

  assign stiff_c = side ? right_stiff_r : left_stiff_r;
  assign damp_c  = side ? right_damp_r  : left_damp_r;

  always_comb begin
    req_pitch.start  = accept;
    req_pitch.side   = side;
    req_pitch.torque = in_tdata[31:0];
    req_pitch.stiff  = stiff_c[31:0];
    req_pitch.damp   = damp_c[31:0];
    req_pitch.dt     = step_time_r;
    req_roll.start   = accept;
    req_roll.side    = side;
    req_roll.torque  = in_tdata[63:32];
    req_roll.stiff   = stiff_c[63:32];
    req_roll.damp    = damp_c[63:32];
    req_roll.dt      = step_time_r;
  end

  fdre_lane #(.MAX_WINDOW(MAX_WINDOW), .SLOT_W(SLOT_W), .CNT_W(CNT_W)) u_pitch (
    .clk (clk), .rst_n (rst_n), .req (req_pitch), .slot (slot_c), .fill (fill_nxt),
    .full (full_c), .clear (clear), .res (res_pitch)
  );

  fdre_lane #(.MAX_WINDOW(MAX_WINDOW), .SLOT_W(SLOT_W), .CNT_W(CNT_W)) u_roll (
    .clk (clk), .rst_n (rst_n), .req (req_roll), .slot (slot_c), .fill (fill_nxt),
    .full (full_c), .clear (clear), .res (res_roll)
  );

  // Merge: the lanes can finish at different times, so wait for both.
  assign capture = busy_r && res_pitch.done && res_roll.done && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_stiff_r  <= 64'h0000000100000001;
      left_damp_r   <= '0;
      right_stiff_r <= 64'h0000000100000001;
      right_damp_r  <= '0;
      step_time_r   <= 24'd16777;
      window_len_r  <= 7'd10;
      slot_r[0]     <= '0;
      slot_r[1]     <= '0;
      fill_r[0]     <= '0;
      fill_r[1]     <= '0;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fdre_pkg::REG_LEFT_STIFF:  left_stiff_r  <= cfg_data;
          fdre_pkg::REG_LEFT_DAMP:   left_damp_r   <= cfg_data;
          fdre_pkg::REG_RIGHT_STIFF: right_stiff_r <= cfg_data;
          fdre_pkg::REG_RIGHT_DAMP:  right_damp_r  <= cfg_data;
          fdre_pkg::REG_STEP_TIME:   step_time_r   <= cfg_data[23:0];
          fdre_pkg::REG_WINDOW_LEN: begin
            window_len_r <= cfg_data[6:0];
            slot_r[0]    <= '0;
            slot_r[1]    <= '0;
            fill_r[0]    <= '0;
            fill_r[1]    <= '0;
          end
          default: ;
        endcase
      end
      if (accept) begin
        busy_r       <= 1'b1;
        slot_r[side] <= slot_nxt;
        fill_r[side] <= fill_nxt;
      end
      if (capture) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
        out_data_r  <= {res_roll.avg, res_pitch.avg, res_roll.defl, res_pitch.defl};
        out_sat_r   <= res_pitch.flag | res_roll.flag;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

endmodule

>>> rtl/core/fdre_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. The dividend is left aligned
// so that only the requested number of top bits are processed.
module fdre_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fdre_pkg::DVD_W-1:0] dividend,
  input  logic [fdre_pkg::DVS_W-1:0] divisor,
  input  logic [fdre_pkg::ITER_W-1:0] iters,
  output logic                       done,
  output logic [fdre_pkg::DVD_W-1:0] quotient,
  output logic [fdre_pkg::DVS_W-1:0] remainder
);

  logic [fdre_pkg::DVD_W-1:0]  dvd_r, quo_r;
  logic [fdre_pkg::DVS_W-1:0]  dvs_r, rem_r;
  logic [fdre_pkg::ITER_W-1:0] cnt_r;
  logic                        busy_r, done_r;
  logic [fdre_pkg::DVS_W:0]    trial;
  logic                        ge;
  logic [fdre_pkg::DVS_W-1:0]  rem_nxt;

  assign trial   = {rem_r, dvd_r[fdre_pkg::DVD_W-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? fdre_pkg::DVS_W'(trial - {1'b0, dvs_r})
                      : fdre_pkg::DVS_W'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= iters;
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[fdre_pkg::DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[fdre_pkg::DVD_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == fdre_pkg::ITER_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> rtl/core/fdre_lane.sv
`timescale 1ns / 1ps
// One axis: spring-damper deflection, instantaneous rate and windowed average
// for both sides, sharing one multiplier and one divider.
module fdre_lane #(
  parameter int MAX_WINDOW = 64,
  parameter int SLOT_W     = 6,
  parameter int CNT_W      = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fdre_pkg::lane_req_t  req,
  input  logic [SLOT_W-1:0]    slot,
  input  logic [CNT_W-1:0]     fill,
  input  logic                 full,
  input  logic                 clear,
  output fdre_pkg::lane_res_t  res
);

  localparam int ADDR_W = (2 * MAX_WINDOW > 1) ? $clog2(2 * MAX_WINDOW) : 1;
  localparam int DW = fdre_pkg::DVD_W;
  localparam int SW = fdre_pkg::DVS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MA, S_MB, S_MC, S_NUM, S_MAG, S_D1, S_W1, S_R1,
    S_D2, S_W2, S_SUM, S_A1, S_W3, S_FIN
  } state_t;

  state_t state_r;

  logic               side_r;
  logic signed [31:0] torque_r;
  logic [31:0]        stiff_r, damp_r;
  logic [23:0]        dt_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [CNT_W-1:0]   fill_r;
  logic               full_r;

  logic signed [31:0] prev_r [2];
  logic signed [39:0] sum_r  [2];
  logic signed [31:0] hist [0:2*MAX_WINDOW-1];
  logic signed [31:0] hist_rd_r;

  logic signed [63:0] a_r;
  logic signed [55:0] b_r;
  logic [55:0]        sd_r;
  logic [DW-1:0]      num_r, mag_r;
  logic [SW-1:0]      den_r;
  logic               neg_r, rneg_r, aneg_r, flag_r, done_r;
  logic [31:0]        defl_r, avg_r;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [31:0] prev_cur;

  logic               div_start;
  logic [DW-1:0]      div_dvd;
  logic [SW-1:0]      div_dvs;
  logic [fdre_pkg::ITER_W-1:0] div_iters;
  logic               div_done;
  logic [DW-1:0]      div_q;
  logic [SW-1:0]      div_r;

  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [23:0]        dt_eff;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [57:0]        rate_dvd;
  logic [39:0]        sum_mag;
  logic [40:0]        avg_dvd;
  logic [DW-1:0]      q_round;
  fdre_pkg::sat_t     defl_sat, rate_sat;
  logic signed [39:0] sum_new;

  assign prev_cur = prev_r[side_r];

  always_comb begin
    case (state_r)
      S_MA:    begin ma = {prev_cur[31], prev_cur};   mb = {1'b0, damp_r}; end
      S_MB:    begin ma = {torque_r[31], torque_r};   mb = {9'b0, dt_r};   end
      S_MC:    begin ma = {1'b0, stiff_r};            mb = {9'b0, dt_r};   end
      default: begin ma = '0;                         mb = '0;             end
    endcase
  end
  assign prod = ma * mb;

  assign rd_addr = req.side ? ADDR_W'(MAX_WINDOW) + ADDR_W'(slot) : ADDR_W'(slot);
  assign wr_addr = side_r ? ADDR_W'(MAX_WINDOW) + ADDR_W'(slot_r) : ADDR_W'(slot_r);

  // Deflection rounding: bump the quotient when twice the remainder reaches
  // the divisor. A zero divisor gives the extreme value of the sign, or zero for a zero numerator.
  always_comb begin
    if (den_r == '0) begin
      q_round = (mag_r != '0) ? '1 : '0;
    end else begin
      q_round = div_q + DW'(div_r >= SW'(den_r - div_r));
    end
    defl_sat = fdre_pkg::sat32(neg_r, q_round);
  end

  assign dt_eff   = (dt_r == '0) ? 24'd1 : dt_r;
  assign diff     = {defl_r[31], defl_r} - {prev_cur[31], prev_cur};
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign rate_dvd = {1'b0, diff_mag, 24'b0} + 58'(dt_eff >> 1);
  assign rate_sat = fdre_pkg::sat32(rneg_r, div_q);
  assign sum_new  = sum_r[side_r]
                  - (full_r ? 40'(hist_rd_r) : 40'sd0)
                  + 40'(signed'(rate_sat.val));
  assign sum_mag  = sum_r[side_r][39] ? 40'(-sum_r[side_r]) : 40'(sum_r[side_r]);
  assign avg_dvd  = {1'b0, sum_mag} + 41'(fill_r >> 1);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = mag_r;
    div_dvs   = den_r;
    div_iters = fdre_pkg::DEFL_ITERS;
    case (state_r)
      S_D1: div_start = 1'b1;
      S_D2: begin
        div_start = 1'b1;
        div_dvd   = {rate_dvd, 32'b0};
        div_dvs   = SW'(dt_eff);
        div_iters = fdre_pkg::RATE_ITERS;
      end
      S_A1: begin
        div_start = 1'b1;
        div_dvd   = {avg_dvd, 49'b0};
        div_dvs   = SW'(fill_r);
        div_iters = fdre_pkg::AVG_ITERS;
      end
      default: ;
    endcase
  end

  fdre_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .iters     (div_iters),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (req.start) hist_rd_r <= hist[rd_addr];
    if (state_r == S_SUM) hist[wr_addr] <= rate_sat.val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      done_r    <= 1'b0;
      prev_r[0] <= '0;
      prev_r[1] <= '0;
      sum_r[0]  <= '0;
      sum_r[1]  <= '0;
    end else begin
      if (clear) begin
        sum_r[0] <= '0;
        sum_r[1] <= '0;
      end
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            side_r   <= req.side;
            torque_r <= req.torque;
            stiff_r  <= req.stiff;
            damp_r   <= req.damp;
            dt_r     <= req.dt;
            slot_r   <= slot;
            fill_r   <= fill;
            full_r   <= full;
            flag_r   <= 1'b0;
            done_r   <= 1'b0;
            state_r  <= S_MA;
          end
        end
        S_MA: begin a_r <= prod[63:0]; state_r <= S_MB; end
        S_MB: begin b_r <= prod[55:0]; state_r <= S_MC; end
        S_MC: begin sd_r <= prod[55:0]; state_r <= S_NUM; end
        S_NUM: begin
          num_r   <= DW'({{26{a_r[63]}}, a_r} <<< 24) - DW'({{34{b_r[55]}}, b_r} <<< 16);
          den_r   <= {1'b0, sd_r} + {1'b0, damp_r, 24'b0};
          state_r <= S_MAG;
        end
        S_MAG: begin
          neg_r   <= num_r[DW-1];
          mag_r   <= num_r[DW-1] ? DW'(-num_r) : num_r;
          state_r <= (den_r == '0) ? S_R1 : S_D1;
        end
        S_D1: state_r <= S_W1;
        S_W1: if (div_done) state_r <= S_R1;
        S_R1: begin
          defl_r  <= defl_sat.val;
          flag_r  <= flag_r | defl_sat.flag;
          state_r <= S_D2;
        end
        S_D2: begin
          rneg_r  <= diff[32];
          state_r <= S_W2;
        end
        S_W2: if (div_done) state_r <= S_SUM;
        S_SUM: begin
          sum_r[side_r]  <= sum_new;
          prev_r[side_r] <= defl_r;
          flag_r         <= flag_r | rate_sat.flag;
          state_r        <= S_A1;
        end
        S_A1: begin
          aneg_r  <= sum_r[side_r][39];
          state_r <= S_W3;
        end
        S_W3: if (div_done) state_r <= S_FIN;
        S_FIN: begin
          avg_r   <= aneg_r ? 32'(-div_q[31:0]) : div_q[31:0];
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.defl = defl_r;
  assign res.avg  = avg_r;
  assign res.flag = flag_r;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int LIMIT = 3000000;
  localparam int SETTLE = 300;
  localparam int BUF_N = 2048;
  localparam logic [2:0] REG_NONE = 3'd6;
  localparam logic [2:0] REG_SPARE = 3'd7;

  typedef struct {
    logic        side;
    logic [31:0] tq_pitch;
    logic [31:0] tq_roll;
  } torque_t;

  typedef struct {
    logic [31:0] defl_p, defl_r, rate_p, rate_r;
    logic        sat;
  } flex_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_valid, cfg_ready;
  logic [63:0] in_tdata;
  logic [0:0] in_tuser, out_tuser;
  logic [127:0] out_tdata;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  flex_deflection_rate_estimator dut (.*);

  // Predictor state.
  logic [63:0] stiff_r[2], damp_r[2];
  logic [23:0] dt_r;
  logic [6:0] win_r;
  logic signed [31:0] prev_defl[4];
  logic signed [31:0] rate_hist[4][64];
  longint rate_acc[4];
  int unsigned fill_n[2], slot_n[2];

  // Pending requests and expected results, each a ring with head and tail counts.
  torque_t torque_buf[BUF_N];
  int tq_head = 0;
  int tq_tail = 0;
  flex_t flex_buf[BUF_N];
  int fx_head = 0;
  int fx_tail = 0;
  int errors = 0;
  int cyc = 0;
  bit in_taken = 0;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void stash_torque(torque_t t);
    torque_buf[tq_tail % BUF_N] = t;
    tq_tail++;
  endfunction

  function automatic logic [31:0] clip(bit neg, logic [127:0] mag, inout bit flag);
    if (neg) begin
      if (mag > 128'h80000000) begin
        flag = 1;
        return 32'h80000000;
      end
      return 32'(-mag);
    end
    if (mag > 128'h7FFFFFFF) begin
      flag = 1;
      return 32'h7FFFFFFF;
    end
    return mag[31:0];
  endfunction

  function automatic logic [31:0] spring_defl(logic signed [31:0] prev, logic signed [31:0] tq,
                                              logic [31:0] stiff, logic [31:0] damp,
                                              logic [23:0] dt, inout bit flag);
    logic signed [127:0] a, b, num;
    logic [127:0] mag, den, q, r;
    bit neg;
    a = 128'(longint'(prev) * longint'({32'b0, damp}));
    b = 128'(longint'(tq) * longint'({40'b0, dt}));
    num = (a <<< 24) - (b <<< 16);
    neg = num[127];
    mag = neg ? -num : num;
    den = 128'({32'b0, stiff} * {40'b0, dt}) + (128'(damp) << 24);
    if (den == 0) begin
      q = (mag != 0) ? {128{1'b1}} : 0;
    end else begin
      q = mag / den;
      r = mag % den;
      if (r >= den - r) q = q + 1;
    end
    return clip(neg, q, flag);
  endfunction

  function automatic logic [31:0] rate_of(logic signed [31:0] now, logic signed [31:0] prev,
                                          logic [23:0] dt, inout bit flag);
    longint diff;
    longint unsigned m, d;
    diff = longint'(now) - longint'(prev);
    m = (diff < 0) ? -diff : diff;
    d = (dt == 0) ? 1 : dt;
    m = m << 24;
    return clip(diff < 0, 128'((m + d / 2) / d), flag);
  endfunction

  function automatic logic [31:0] mean_of(longint sum, int unsigned n);
    longint unsigned m, q;
    m = (sum < 0) ? -sum : sum;
    q = (m + n / 2) / n;
    return (sum < 0) ? 32'(-q) : 32'(q);
  endfunction

  function automatic flex_t predict_flex(torque_t t);
    flex_t e;
    bit flag;
    int unsigned s, len, slot, fill, k;
    logic signed [31:0] tq[2];
    logic [31:0] dv[2], av[2];
    logic signed [31:0] rt;
    flag = 0;
    s = t.side;
    tq[0] = t.tq_pitch;
    tq[1] = t.tq_roll;
    len = win_r;
    if (len == 0) len = 1;
    if (len > 64) len = 64;
    slot = slot_n[s];
    fill = fill_n[s];
    if (slot >= len) slot = 0;
    if (fill > len) fill = len;
    for (int ax = 0; ax < 2; ax++) begin
      k = s * 2 + ax;
      dv[ax] = spring_defl(prev_defl[k], tq[ax], stiff_r[s][32*ax +: 32],
                           damp_r[s][32*ax +: 32], dt_r, flag);
      rt = rate_of(dv[ax], prev_defl[k], dt_r, flag);
      if (fill >= len) rate_acc[k] -= longint'(rate_hist[k][slot]);
      rate_acc[k] += longint'(rt);
      rate_hist[k][slot] = rt;
      prev_defl[k] = dv[ax];
    end
    if (fill < len) fill++;
    slot++;
    if (slot >= len) slot = 0;
    fill_n[s] = fill;
    slot_n[s] = slot;
    for (int ax = 0; ax < 2; ax++) av[ax] = mean_of(rate_acc[s * 2 + ax], fill);
    e.defl_p = dv[0];
    e.defl_r = dv[1];
    e.rate_p = av[0];
    e.rate_r = av[1];
    e.sat = flag;
    return e;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cyc);
  endtask

  // The acceptance of a request is noted here and acted on at the falling edge.
  always @(posedge clk) begin
    flex_t e;
    torque_t t;
    if (rst_n && in_tvalid && in_tready) begin
      t.side = in_tuser[0];
      t.tq_pitch = in_tdata[31:0];
      t.tq_roll = in_tdata[63:32];
      flex_buf[fx_tail % BUF_N] = predict_flex(t);
      fx_tail++;
      in_taken = 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (fx_head == fx_tail) begin
        report("unexpected result", out_tdata[31:0], 32'd0);
      end else begin
        e = flex_buf[fx_head % BUF_N];
        fx_head++;
        if (out_tdata[31:0] !== e.defl_p) report("deflection_pitch", out_tdata[31:0], e.defl_p);
        if (out_tdata[63:32] !== e.defl_r) report("deflection_roll", out_tdata[63:32], e.defl_r);
        if (out_tdata[95:64] !== e.rate_p) report("rate_pitch", out_tdata[95:64], e.rate_p);
        if (out_tdata[127:96] !== e.rate_r) report("rate_roll", out_tdata[127:96], e.rate_r);
        if (out_tuser[0] !== e.sat) report("saturated", 32'(out_tuser[0]), 32'(e.sat));
      end
    end
  end

  // Idling is switched off for one long stretch in each repeating period.
  function automatic bit take_break();
    return ((cyc % 200000) < 150000) && ($urandom_range(99) < 38);
  endfunction

  always @(negedge clk) begin
    torque_t t;
    if (rst_n) begin
      out_tready <= !take_break();
      if (!in_tvalid || in_taken) begin
        in_taken = 0;
        if (tq_head != tq_tail && !take_break()) begin
          t = torque_buf[tq_head % BUF_N];
          tq_head++;
          in_tuser <= t.side;
          in_tdata <= {t.tq_roll, t.tq_pitch};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Idleness is judged at rising edges, once the falling-edge drive has settled.
  task automatic wait_idle();
    do @(posedge clk); while (tq_head != tq_tail || in_tvalid || fx_head != fx_tail);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fdre_pkg::REG_LEFT_STIFF:  stiff_r[0] = val;
      fdre_pkg::REG_LEFT_DAMP:   damp_r[0] = val;
      fdre_pkg::REG_RIGHT_STIFF: stiff_r[1] = val;
      fdre_pkg::REG_RIGHT_DAMP:  damp_r[1] = val;
      fdre_pkg::REG_STEP_TIME:   dt_r = val[23:0];
      fdre_pkg::REG_WINDOW_LEN: begin
        win_r = val[6:0];
        rate_acc = '{0, 0, 0, 0};
        fill_n = '{0, 0};
        slot_n = '{0, 0};
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return $urandom();
      default: return $urandom_range(32'h100000, 32'h100);
    endcase
  endfunction

  function automatic logic [31:0] pick_torque();
    case ($urandom_range(9))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return $urandom();
      default: return 32'($signed($urandom()) >>> $urandom_range(24, 8));
    endcase
  endfunction

  initial begin
    int wins[8] = '{1, 64, 0, 65, 127, 7, 10, 33};
    logic [23:0] dts[8] = '{24'd1, 24'hFFFFFF, 24'd0, 24'd16777, 24'd65536, 24'd3, 24'd1000, 24'd255};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stiff_r = '{64'h100000001, 64'h100000001};
    damp_r = '{64'h0, 64'h0};
    dt_r = 24'd16777;
    win_r = 7'd10;
    prev_defl = '{0, 0, 0, 0};
    rate_acc = '{0, 0, 0, 0};
    fill_n = '{0, 0};
    slot_n = '{0, 0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: torque extremes on both sides under the reset settings.
    stash_torque('{1'b0, 32'h0, 32'h0});
    stash_torque('{1'b0, 32'h7FFFFFFF, 32'h80000000});
    stash_torque('{1'b1, 32'h80000000, 32'h7FFFFFFF});
    stash_torque('{1'b1, 32'hFFFFFFFF, 32'h00000001});
    stash_torque('{1'b0, 32'h00010000, 32'hFFFF0000});
    wait_idle();
    // Zero denominator on the left, zero step time, empty window and ignored indices.
    write_reg(fdre_pkg::REG_LEFT_STIFF, 64'h0);
    write_reg(fdre_pkg::REG_LEFT_DAMP, 64'h0);
    write_reg(fdre_pkg::REG_RIGHT_STIFF, 64'h0000000100010000);
    write_reg(fdre_pkg::REG_RIGHT_DAMP, 64'hFFFFFFFF00008000);
    write_reg(fdre_pkg::REG_STEP_TIME, 64'h0);
    write_reg(fdre_pkg::REG_WINDOW_LEN, 64'h0);
    write_reg(REG_NONE, 64'hFFFFFFFFFFFFFFFF);
    write_reg(REG_SPARE, 64'h1234);
    @(negedge clk);
    cfg_valid <= 1'b0;
    stash_torque('{1'b0, 32'h0, 32'h0});
    stash_torque('{1'b0, 32'h00001000, 32'hFFFFF000});
    stash_torque('{1'b0, 32'h80000000, 32'h7FFFFFFF});
    stash_torque('{1'b1, 32'h00020000, 32'hFFFE0000});
    stash_torque('{1'b1, 32'h7FFFFFFF, 32'h80000000});
    stash_torque('{1'b1, 32'h0, 32'h0});
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(fdre_pkg::REG_LEFT_STIFF, {pick_gain(), pick_gain()});
      write_reg(fdre_pkg::REG_LEFT_DAMP, {pick_gain(), pick_gain()});
      write_reg(fdre_pkg::REG_RIGHT_STIFF, {pick_gain(), pick_gain()});
      write_reg(fdre_pkg::REG_RIGHT_DAMP, {pick_gain(), pick_gain()});
      write_reg(fdre_pkg::REG_STEP_TIME, {40'($urandom()), dts[ph]});
      write_reg(fdre_pkg::REG_WINDOW_LEN, {57'($urandom()), 7'(wins[ph])});
      @(negedge clk);
      cfg_valid <= 1'b0;
      for (int i = 0; i < 210; i++)
        stash_torque('{1'($urandom()), pick_torque(), pick_torque()});
      wait_idle();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/fdre_pkg.sv
rtl/core/fdre_div.sv
rtl/core/fdre_lane.sv
rtl/core/flex_deflection_rate_estimator.sv
tb/sv/tb_top.sv
